/* rtl/deq_pkg.sv */
// Shared types and constants of the deadline event queue.
// No dependencies; used by the top level, the checker and the testbench.
package deq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int CANCEL_DEPTH_DEF = 16;
    localparam int MAX_RESULTS      = 32;

    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int TAG_W  = 16;
    localparam int DLY_W  = 32;
    localparam int SLOT_W = TIME_W + ID_W + TAG_W;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2
    } in_kind_t;

    typedef enum logic [2:0] {
        RK_ADD_OK    = 3'd0,
        RK_CANCEL_OK = 3'd1,
        RK_DISPATCH  = 3'd2,
        RK_IDLE      = 3'd3,
        RK_FULL      = 3'd4
    } res_kind_t;

endpackage

/* rtl/deadline_event_queue.sv */
// Top level of the deadline event queue: sequencer, slot RAM and cancel-set RAM.
// Depends on deq_pkg and deq_ram.
//
// Timer event queue, earliest deadline first (ties by smaller id, then by
// insertion order). One input transfer is taken at a time; s_tready is high
// only while the sequencer is idle. An add writes the slot RAM and then
// returns its result; a rejected add, an unknown kind or a cancel of id zero
// goes straight to the result. A cancel scans the cancel set entry by entry
// and stops on a hit. A tick repeats, for each event that leaves, a minimum
// search over the slot RAM entry by entry, a compaction of the entries above
// the removed one and a cancel-set lookup; each RAM has a single read port and
// the minimum search has one compare unit, so these steps go one entry at a time.
// Results leave through one output register and wait there for m_tready.
module deadline_event_queue #(
    parameter int QUEUE_DEPTH  = deq_pkg::QUEUE_DEPTH_DEF,
    parameter int CANCEL_DEPTH = deq_pkg::CANCEL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // delay_ms[31:0], event_id[63:32], task_tag[79:64]
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_id[31:0], out_tag[47:32]
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    localparam int QIW  = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW  = (CANCEL_DEPTH > 1) ? $clog2(CANCEL_DEPTH) : 1;
    localparam int NW   = $clog2(deq_pkg::MAX_RESULTS + 1);
    localparam int TW   = deq_pkg::TIME_W;
    localparam int IW   = deq_pkg::ID_W;
    localparam int GW   = deq_pkg::TAG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_RESULT, S_TICK_LOOP, S_SC_RD, S_SC_CMP, S_DECIDE,
        S_SH_CHK, S_SH_WR, S_CS_RD, S_CS_CMP, S_CS_DONE, S_DISP, S_FINISH
    } state_t;

    state_t                state_reg;
    logic [TW-1:0]         now_reg;
    logic [IW-1:0]         next_id_reg;
    logic [CNTW-1:0]       count_reg;
    logic [CANCEL_DEPTH-1:0] cvalid_reg;

    logic [deq_pkg::DLY_W-1:0] delay_reg;
    logic [IW-1:0]         key_reg;
    logic [GW-1:0]         tag_reg;
    deq_pkg::res_kind_t    res_kind_reg;
    logic [IW-1:0]         res_id_reg;
    logic                  mode_tick_reg;

    logic [CNTW-1:0]       scan_reg;
    logic [QIW-1:0]        sh_reg;
    logic [TW-1:0]         best_dl_reg;
    logic [IW-1:0]         best_id_reg;
    logic [GW-1:0]         best_tag_reg;
    logic [QIW-1:0]        best_idx_reg;

    logic [CIW-1:0]        cj_reg;
    logic                  found_reg;
    logic [CIW-1:0]        found_idx_reg;
    logic                  free_v_reg;
    logic [CIW-1:0]        free_idx_reg;

    logic                  pend_v_reg;
    logic [IW-1:0]         pend_id_reg;
    logic [GW-1:0]         pend_tag_reg;
    logic [NW-1:0]         n_reg;

    logic                  out_valid_reg;
    logic [2:0]            out_kind_reg;
    logic [IW-1:0]         out_id_reg;
    logic [GW-1:0]         out_tag_reg;
    logic                  out_last_reg;

    // slot RAM ports
    logic                  s_we;
    logic [QIW-1:0]        s_waddr;
    logic [QIW-1:0]        s_raddr;
    logic [deq_pkg::SLOT_W-1:0] s_wdata;
    logic [deq_pkg::SLOT_W-1:0] s_rdata;

    // cancel RAM ports
    logic                  c_we;
    logic [CIW-1:0]        c_waddr;
    logic [IW-1:0]         c_rdata;

    logic                  out_free;
    logic                  emit;
    logic [2:0]            e_kind;
    logic [IW-1:0]         e_id;
    logic [GW-1:0]         e_tag;
    logic                  e_last;

    logic [TW:0]           dl_sum;
    logic [TW-1:0]         dl_sat;
    logic [IW-1:0]         id_inc;
    logic [IW-1:0]         id_new;
    logic [TW-1:0]         rd_dl;
    logic [IW-1:0]         rd_id;
    logic [GW-1:0]         rd_tag;
    logic                  rd_less;
    logic                  c_hit;
    logic [CNTW-1:0]       sh_up;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_tag_reg, out_id_reg};
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign dl_sum = {1'b0, now_reg} + {{(TW + 1 - deq_pkg::DLY_W){1'b0}}, delay_reg};
    assign dl_sat = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
    assign id_inc = next_id_reg + 1'b1;
    assign id_new = (key_reg != '0) ? key_reg : ((id_inc == '0) ? IW'(1) : id_inc);

    assign rd_dl  = s_rdata[TW-1:0];
    assign rd_id  = s_rdata[TW+IW-1:TW];
    assign rd_tag = s_rdata[deq_pkg::SLOT_W-1:TW+IW];
    // compare unit of the minimum search: (deadline, id) strictly below current best
    assign rd_less = (rd_dl < best_dl_reg) || ((rd_dl == best_dl_reg) && (rd_id < best_id_reg));
    assign c_hit   = cvalid_reg[cj_reg] && (c_rdata == key_reg);
    assign sh_up   = CNTW'(sh_reg) + 1'b1;

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = sh_reg;
        s_wdata = s_rdata;
        s_raddr = scan_reg[QIW-1:0];
        c_we    = 1'b0;
        c_waddr = free_idx_reg;
        unique case (state_reg)
            S_ADD:
            begin
                s_we    = 1'b1;
                s_waddr = count_reg[QIW-1:0];
                s_wdata = {tag_reg, id_new, dl_sat};
            end
            S_SH_CHK: s_raddr = sh_up[QIW-1:0];
            S_SH_WR:  s_we = 1'b1;
            S_CS_DONE: c_we = !mode_tick_reg && !found_reg && free_v_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        emit   = 1'b0;
        e_kind = deq_pkg::RK_IDLE;
        e_id   = '0;
        e_tag  = '0;
        e_last = 1'b1;
        unique case (state_reg)
            S_RESULT:
            begin
                emit   = out_free;
                e_kind = res_kind_reg;
                e_id   = res_id_reg;
            end
            S_DISP:
            begin
                emit   = out_free && pend_v_reg;
                e_kind = deq_pkg::RK_DISPATCH;
                e_id   = pend_id_reg;
                e_tag  = pend_tag_reg;
                e_last = 1'b0;
            end
            S_FINISH:
            begin
                emit = out_free;
                if (pend_v_reg)
                begin
                    e_kind = deq_pkg::RK_DISPATCH;
                    e_id   = pend_id_reg;
                    e_tag  = pend_tag_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            next_id_reg   <= '0;
            count_reg     <= '0;
            cvalid_reg    <= '0;
            delay_reg     <= '0;
            key_reg       <= '0;
            tag_reg       <= '0;
            res_kind_reg  <= deq_pkg::RK_IDLE;
            res_id_reg    <= '0;
            mode_tick_reg <= 1'b0;
            scan_reg      <= '0;
            sh_reg        <= '0;
            best_dl_reg   <= '0;
            best_id_reg   <= '0;
            best_tag_reg  <= '0;
            best_idx_reg  <= '0;
            cj_reg        <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_v_reg    <= 1'b0;
            free_idx_reg  <= '0;
            pend_v_reg    <= 1'b0;
            pend_id_reg   <= '0;
            pend_tag_reg  <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= deq_pkg::RK_IDLE;
            out_id_reg    <= '0;
            out_tag_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= e_kind;
                out_id_reg    <= e_id;
                out_tag_reg   <= e_tag;
                out_last_reg  <= e_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        delay_reg     <= s_tdata[31:0];
                        key_reg       <= s_tdata[63:32];
                        tag_reg       <= s_tdata[79:64];
                        mode_tick_reg <= 1'b0;
                        cj_reg        <= '0;
                        found_reg     <= 1'b0;
                        free_v_reg    <= 1'b0;
                        case (s_tuser)
                            deq_pkg::KIND_ADD:
                            begin
                                if (count_reg == CNTW'(QUEUE_DEPTH))
                                begin
                                    res_kind_reg <= deq_pkg::RK_FULL;
                                    res_id_reg   <= '0;
                                    state_reg    <= S_RESULT;
                                end
                                else
                                begin
                                    state_reg <= S_ADD;
                                end
                            end
                            deq_pkg::KIND_CANCEL:
                            begin
                                res_kind_reg <= deq_pkg::RK_CANCEL_OK;
                                res_id_reg   <= s_tdata[63:32];
                                state_reg    <= (s_tdata[63:32] == '0) ? S_RESULT : S_CS_RD;
                            end
                            deq_pkg::KIND_TICK:
                            begin
                                now_reg    <= now_reg + 1'b1;
                                n_reg      <= '0;
                                pend_v_reg <= 1'b0;
                                state_reg  <= S_TICK_LOOP;
                            end
                            default:
                            begin
                                res_kind_reg <= deq_pkg::RK_IDLE;
                                res_id_reg   <= '0;
                                state_reg    <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (key_reg == '0)
                    begin
                        next_id_reg <= id_new;
                    end
                    count_reg    <= count_reg + 1'b1;
                    res_kind_reg <= deq_pkg::RK_ADD_OK;
                    res_id_reg   <= id_new;
                    state_reg    <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_TICK_LOOP:
                begin
                    scan_reg <= '0;
                    if (count_reg == '0 || n_reg == NW'(deq_pkg::MAX_RESULTS))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_RD: state_reg <= S_SC_CMP;
                S_SC_CMP:
                begin
                    if (scan_reg == '0 || rd_less)
                    begin
                        best_dl_reg  <= rd_dl;
                        best_id_reg  <= rd_id;
                        best_tag_reg <= rd_tag;
                        best_idx_reg <= scan_reg[QIW-1:0];
                    end
                    scan_reg  <= scan_reg + 1'b1;
                    state_reg <= (scan_reg + 1'b1 == count_reg) ? S_DECIDE : S_SC_RD;
                end
                S_DECIDE:
                begin
                    sh_reg    <= best_idx_reg;
                    state_reg <= (best_dl_reg > now_reg) ? S_FINISH : S_SH_CHK;
                end
                S_SH_CHK:
                begin
                    if (sh_up < count_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        // compaction done; look the id up in the cancel set
                        count_reg     <= count_reg - 1'b1;
                        key_reg       <= best_id_reg;
                        mode_tick_reg <= 1'b1;
                        cj_reg        <= '0;
                        found_reg     <= 1'b0;
                        free_v_reg    <= 1'b0;
                        state_reg     <= S_CS_RD;
                    end
                end
                S_SH_WR:
                begin
                    sh_reg    <= sh_up[QIW-1:0];
                    state_reg <= S_SH_CHK;
                end
                S_CS_RD: state_reg <= S_CS_CMP;
                S_CS_CMP:
                begin
                    if (c_hit)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= cj_reg;
                        state_reg     <= S_CS_DONE;
                    end
                    else
                    begin
                        if (!cvalid_reg[cj_reg] && !free_v_reg)
                        begin
                            free_v_reg   <= 1'b1;
                            free_idx_reg <= cj_reg;
                        end
                        cj_reg    <= cj_reg + 1'b1;
                        state_reg <= (cj_reg == CIW'(CANCEL_DEPTH - 1)) ? S_CS_DONE : S_CS_RD;
                    end
                end
                S_CS_DONE:
                begin
                    if (mode_tick_reg)
                    begin
                        if (found_reg)
                        begin
                            cvalid_reg[found_idx_reg] <= 1'b0;
                            state_reg <= S_TICK_LOOP;
                        end
                        else
                        begin
                            state_reg <= S_DISP;
                        end
                    end
                    else
                    begin
                        if (!found_reg && free_v_reg)
                        begin
                            cvalid_reg[free_idx_reg] <= 1'b1;
                        end
                        if (!found_reg && !free_v_reg)
                        begin
                            res_kind_reg <= deq_pkg::RK_FULL;
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_DISP:
                begin
                    // hold one dispatch back so the final one can carry tlast
                    if (!pend_v_reg || out_free)
                    begin
                        pend_v_reg   <= 1'b1;
                        pend_id_reg  <= best_id_reg;
                        pend_tag_reg <= best_tag_reg;
                        n_reg        <= n_reg + 1'b1;
                        state_reg    <= S_TICK_LOOP;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        pend_v_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    deq_ram #(
        .WIDTH(deq_pkg::SLOT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    deq_ram #(
        .WIDTH(IW),
        .DEPTH(CANCEL_DEPTH)
    ) u_cancel_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (key_reg),
        .raddr (cj_reg),
        .rdata (c_rdata)
    );

endmodule

/* rtl/deq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/deq_checker.sv */
// Port-level checks of the deadline event queue, bound to the top level.
// Depends on deq_pkg and deadline_event_queue.
module deq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // one item at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= deq_pkg::RK_FULL))
        else $error("result kind out of range");

    // only dispatches may be non-final
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != deq_pkg::RK_DISPATCH)) |-> m_tlast)
        else $error("non-dispatch result without tlast");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind deadline_event_queue deq_checker u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* verif/tb.sv */
// Testbench of deadline_event_queue: directed and random adds, cancels and ticks,
// checked against a behavioral model of the queue held in this file.
// Depends on deq_pkg and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QD = deq_pkg::QUEUE_DEPTH_DEF;
    localparam int CD = deq_pkg::CANCEL_DEPTH_DEF;
    localparam int WATCHDOG = 200000;
    localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delay;
        logic [31:0] id;
        logic [15:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  rk;
        logic [31:0] id;
        logic [15:0] tag;
        logic        last;
    } res_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    deadline_event_queue DUT (.*);

    always #4 clk = ~clk;

    // queue model state
    logic [47:0] now_ms;
    logic [31:0] id_ctr;
    logic [47:0] q_dl [QD];
    logic [31:0] q_id [QD];
    logic [15:0] q_tag [QD];
    int          q_n;
    logic [31:0] mark_key [CD];
    logic        mark_on [CD];

    cmd_t pending[$];
    res_t expected[$];
    int   errors = 0;
    int   n_sent = 0, n_recv = 0, n_disp = 0;
    bit   no_idle = 0;
    bit   hold_tx = 0;
    int   quiet = 0;

    function automatic int find_mark(logic [31:0] id);
        for (int i = 0; i < CD; i++)
            if (mark_on[i] && mark_key[i] == id) return i;
        return -1;
    endfunction

    function automatic void push_res(deq_pkg::res_kind_t rk, logic [31:0] id,
                                     logic [15:0] tag, logic last);
        res_t r;
        r.rk = rk; r.id = id; r.tag = tag; r.last = last;
        expected.insert(expected.size(), r);
    endfunction

    function automatic void predict_queue(cmd_t c);
        logic [48:0] sum;
        logic [31:0] id;
        int b, m, n, slot;
        case (c.kind)
            deq_pkg::KIND_ADD:
            begin
                if (q_n >= QD)
                    push_res(deq_pkg::RK_FULL, 0, 0, 1);
                else
                begin
                    id = c.id;
                    if (id == 0)
                    begin
                        id_ctr = id_ctr + 1;
                        if (id_ctr == 0) id_ctr = 1;
                        id = id_ctr;
                    end
                    sum = {1'b0, now_ms} + {17'd0, c.delay};
                    q_dl[q_n] = sum[48] ? T_MAX : sum[47:0];
                    q_id[q_n] = id;
                    q_tag[q_n] = c.tag;
                    q_n++;
                    push_res(deq_pkg::RK_ADD_OK, id, 0, 1);
                end
            end
            deq_pkg::KIND_CANCEL:
            begin
                if (c.id == 0 || find_mark(c.id) >= 0)
                    push_res(deq_pkg::RK_CANCEL_OK, c.id, 0, 1);
                else
                begin
                    slot = -1;
                    for (int i = 0; i < CD; i++)
                        if (!mark_on[i] && slot < 0) slot = i;
                    if (slot >= 0)
                    begin
                        mark_on[slot] = 1;
                        mark_key[slot] = c.id;
                        push_res(deq_pkg::RK_CANCEL_OK, c.id, 0, 1);
                    end
                    else
                        push_res(deq_pkg::RK_FULL, c.id, 0, 1);
                end
            end
            deq_pkg::KIND_TICK:
            begin
                n = 0;
                now_ms = now_ms + 1;
                while (q_n > 0 && n < deq_pkg::MAX_RESULTS)
                begin
                    b = 0;
                    for (int i = 1; i < q_n; i++)
                        if (q_dl[i] < q_dl[b] || (q_dl[i] == q_dl[b] && q_id[i] < q_id[b]))
                            b = i;
                    if (q_dl[b] > now_ms) break;
                    id = q_id[b];
                    push_res(deq_pkg::RK_DISPATCH, id, q_tag[b], 0);
                    for (int i = b; i + 1 < q_n; i++)
                    begin
                        q_dl[i] = q_dl[i + 1];
                        q_id[i] = q_id[i + 1];
                        q_tag[i] = q_tag[i + 1];
                    end
                    q_n--;
                    m = find_mark(id);
                    if (m >= 0)
                    begin
                        mark_on[m] = 0;
                        expected.delete(expected.size() - 1);
                    end
                    else
                        n++;
                end
                if (n == 0)
                    push_res(deq_pkg::RK_IDLE, 0, 0, 1);
                else
                    expected[expected.size() - 1].last = 1;
            end
            default:
                push_res(deq_pkg::RK_IDLE, 0, 0, 1);
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_queue(cmd_t'({s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64]}));
                n_sent++;
            end
            if ((!s_tvalid || s_tready) )
            begin
                if (pending.size() > 0 && !hold_tx && (no_idle || $urandom_range(99) >= 11))
                begin
                    cmd_t c;
                    c = pending.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= c.kind;
                    s_tdata <= {c.tag, c.id, c.delay};
                end
                else
                    s_tvalid <= 0;
            end
            m_tready <= no_idle || $urandom_range(99) >= 11;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > WATCHDOG)
            begin
                $display("watchdog expired at %0t", $time);
                $display("== FAIL ==");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                n_recv++;
                if (expected.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none, got kind=%0d id=%h",
                             $time, m_tuser, m_tdata[31:0]);
                end
                else
                begin
                    res_t e;
                    e = expected.pop_front();
                    if (e.rk == deq_pkg::RK_DISPATCH) n_disp++;
                    if (m_tuser !== e.rk || m_tdata[31:0] !== e.id || m_tdata[47:32] !== e.tag
                        || m_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t mismatch: expected kind=%0d id=%h tag=%h last=%b, got kind=%0d id=%h tag=%h last=%b",
                                 $time, e.rk, e.id, e.tag, e.last,
                                 m_tuser, m_tdata[31:0], m_tdata[47:32], m_tlast);
                    end
                end
            end
        end
    end

    task automatic add_cmd(logic [1:0] k, logic [31:0] d, logic [31:0] id, logic [15:0] tag);
        cmd_t c;
        c.kind = k; c.delay = d; c.id = id; c.tag = tag;
        pending.insert(pending.size(), c);
    endtask

    task automatic drain();
        while (pending.size() > 0 || s_tvalid || expected.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_delay();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(6);
        endcase
    endfunction

    initial
    begin
        now_ms = 0; id_ctr = 0; q_n = 0;
        for (int i = 0; i < CD; i++)
        begin
            mark_on[i] = 0;
            mark_key[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, preset ids, ties, cancels, unknown kind
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        add_cmd(deq_pkg::KIND_ADD, 0, 0, 16'hFFFF);
        add_cmd(deq_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        add_cmd(deq_pkg::KIND_ADD, 1, 32'd9, 16'h1234);
        add_cmd(deq_pkg::KIND_ADD, 1, 32'd5, 16'h4321);
        add_cmd(deq_pkg::KIND_ADD, 1, 32'd5, 16'h5555);
        add_cmd(deq_pkg::KIND_ADD, 2, 0, 16'hAAAA);
        add_cmd(deq_pkg::KIND_CANCEL, 0, 0, 0);
        add_cmd(deq_pkg::KIND_CANCEL, 0, 32'd9, 0);
        add_cmd(deq_pkg::KIND_CANCEL, 0, 32'd9, 0);
        add_cmd(deq_pkg::KIND_CANCEL, 0, 32'h7777_0000, 0);
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        add_cmd(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        drain();

        // fill the queue past full, all due on the next tick
        for (int i = 0; i < QD + 2; i++)
            add_cmd(deq_pkg::KIND_ADD, 0, (i % 3 == 0) ? 32'd0 : $urandom, $urandom);
        // fill the cancel set past full
        for (int i = 0; i < CD + 2; i++)
            add_cmd(deq_pkg::KIND_CANCEL, 0, 32'h8000_0000 + i, 0);
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        add_cmd(deq_pkg::KIND_TICK, 0, 0, 0);
        drain();
        // every result is back; the sender is held off before the random phase
        hold_tx = 1;
        repeat (20) @(posedge clk);
        hold_tx = 0;

        // random: mostly add/tick, with cancels of ids near the id counter or random ids
        for (int i = 0; i < 150; i++)
        begin
            int r;
            r = $urandom_range(99);
            if (i == 40) no_idle = 1;
            if (i == 100) no_idle = 0;
            if (r < 45)
                add_cmd(deq_pkg::KIND_ADD, rnd_delay(),
                        ($urandom_range(4) == 0) ? $urandom : 32'd0, $urandom);
            else if (r < 60)
                add_cmd(deq_pkg::KIND_CANCEL, 0,
                        ($urandom_range(3) == 0) ? $urandom
                                                 : id_ctr + $urandom_range(8), 0);
            else if (r < 97)
                add_cmd(deq_pkg::KIND_TICK, $urandom, $urandom, $urandom);
            else
                add_cmd(2'd3, $urandom, $urandom, $urandom);
            if (i % 20 == 19) drain();
        end
        drain();
        repeat (200) @(posedge clk);

        $display("sent %0d commands, checked %0d results including %0d dispatches",
                 n_sent, n_recv, n_disp);
        if (errors == 0 && expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* deadline_event_queue.f */
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deadline_event_queue.sv
rtl/deq_checker.sv
verif/tb.sv
